// ===== hw/rtl/postfix_stack_evaluator_assert.svh =====
// Assertion macros shared by the postfix stack evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PSE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("postfix evaluator: invariant violated");
`define PSE_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("postfix evaluator: implication violated");
`define PSE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("postfix evaluator: next-cycle check violated");
`else
`define PSE_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PSE_ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define PSE_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== hw/rtl/pse_pkg.sv =====
// Shared types, constants and helper functions of the postfix stack evaluator.
package pse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5E;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_XOR = 3'd5
  } op_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expr;
  } pse_in_t;

  typedef struct packed {
    logic signed [7:0] value;
    status_e           status;
  } pse_out_t;

  // Command bundle from the sequencer to the stack.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       peek;
    logic       clear;
    logic [7:0] wdata;
  } pse_stk_cmd_t;

  // Stack occupancy flags back to the sequencer.
  typedef struct packed {
    logic empty;
    logic full;
  } pse_stk_sts_t;

  typedef struct packed {
    logic is_push;
    logic is_op;
    op_e  op;
  } pse_cls_t;

  function automatic pse_cls_t decode_char(input logic [7:0] c);
    pse_cls_t cls;
    cls.is_push = (c inside {[CH_ZERO:CH_NINE], [CH_UA:CH_UZ], [CH_LA:CH_LZ]});
    cls.is_op   = 1'b1;
    cls.op      = OP_ADD;
    case (c)
      CH_PLUS:  cls.op = OP_ADD;
      CH_MINUS: cls.op = OP_SUB;
      CH_STAR:  cls.op = OP_MUL;
      CH_SLASH: cls.op = OP_DIV;
      CH_PCT:   cls.op = OP_MOD;
      CH_CARET: cls.op = OP_XOR;
      default:  cls.is_op = 1'b0;
    endcase
    return cls;
  endfunction

  // Keeps the first error of an expression.
  function automatic status_e note_err(input status_e cur, input status_e code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

// ===== hw/rtl/pse_stack.sv =====
// Value stack: a memory with a fill count and a registered top read.
`include "postfix_stack_evaluator_assert.svh"
module pse_stack import pse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pse_stk_cmd_t cmd_i,
  output pse_stk_sts_t sts_o,
  output logic [7:0]   rdata_o
);

  logic [7:0]        mem [STACK_DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  count_m1;
  logic [ADDR_W-1:0] top_idx;
  logic [7:0]        rdata_q;
  logic              empty, full;

  assign empty    = (count_q == '0);
  assign full     = (count_q == CNT_W'(STACK_DEPTH));
  assign count_m1 = count_q - CNT_W'(1);
  assign top_idx  = count_m1[ADDR_W-1:0];

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push && !full) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop && !empty) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full && !cmd_i.clear) begin
      mem[count_q[ADDR_W-1:0]] <= cmd_i.wdata;
    end
    if ((cmd_i.pop || cmd_i.peek) && !empty) begin
      rdata_q <= mem[top_idx];
    end
  end

  assign sts_o.empty = empty;
  assign sts_o.full  = full;
  assign rdata_o     = rdata_q;

  `PSE_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(STACK_DEPTH))
  `PSE_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, cmd_i.push && !full && !cmd_i.clear, count_q == $past(count_q) + CNT_W'(1))
  `PSE_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, cmd_i.clear, count_q == '0)

endmodule

// ===== hw/rtl/pse_alu.sv =====
// Shared 8-bit arithmetic unit with an iterative restoring divider.
`include "postfix_stack_evaluator_assert.svh"
module pse_alu import pse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  op_e               op_i,
  input  logic signed [7:0] a_i,
  input  logic signed [7:0] b_i,
  output logic              done_o,
  output logic [7:0]        result_o,
  output logic              divz_o
);

  typedef enum logic [2:0] {
    AL_IDLE = 3'b001,
    AL_DIV  = 3'b010,
    AL_FIX  = 3'b100
  } alu_state_e;

  alu_state_e        state_q, state_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [7:0]        dvd_q, dvd_d;
  logic [7:0]        rem_q, rem_d;
  logic [7:0]        dsr_q, dsr_d;
  logic              negq_q, negq_d, negr_q, negr_d, mod_q, mod_d;
  logic [7:0]        res_q, res_d;
  logic              divz_q, divz_d;
  logic              done_q, done_d;
  logic signed [15:0] prod;
  logic [7:0]        mag_a, mag_b;
  logic [8:0]        trial, diff;
  logic              ge;

  assign prod  = a_i * b_i;
  assign mag_a = a_i[7] ? (~a_i + 8'd1) : a_i;
  assign mag_b = b_i[7] ? (~b_i + 8'd1) : b_i;
  assign trial = {rem_q, dvd_q[7]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    negq_d  = negq_q;
    negr_d  = negr_q;
    mod_d   = mod_q;
    res_d   = res_q;
    divz_d  = divz_q;
    done_d  = 1'b0;
    case (state_q)
      AL_IDLE: begin
        if (start_i) begin
          divz_d = 1'b0;
          case (op_i)
            OP_ADD: begin res_d = a_i + b_i; done_d = 1'b1; end
            OP_SUB: begin res_d = a_i - b_i; done_d = 1'b1; end
            OP_MUL: begin res_d = prod[7:0]; done_d = 1'b1; end
            OP_DIV, OP_MOD: begin
              if (b_i == '0) begin
                res_d  = '0;
                divz_d = 1'b1;
                done_d = 1'b1;
              end else begin
                dvd_d   = mag_a;
                dsr_d   = mag_b;
                rem_d   = '0;
                cnt_d   = '0;
                negq_d  = a_i[7] ^ b_i[7];
                negr_d  = a_i[7];
                mod_d   = (op_i == OP_MOD);
                state_d = AL_DIV;
              end
            end
            default: begin res_d = a_i ^ b_i; done_d = 1'b1; end
          endcase
        end
      end
      AL_DIV: begin
        // One quotient bit per cycle; the dividend register fills with quotient bits.
        rem_d = ge ? diff[7:0] : trial[7:0];
        dvd_d = {dvd_q[6:0], ge};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = AL_FIX;
        end
      end
      AL_FIX: begin
        if (mod_q) begin
          res_d = negr_q ? (~rem_q + 8'd1) : rem_q;
        end else begin
          res_d = negq_q ? (~dvd_q + 8'd1) : dvd_q;
        end
        done_d  = 1'b1;
        state_d = AL_IDLE;
      end
      default: state_d = AL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
    mod_q  <= mod_d;
    res_q  <= res_d;
    divz_q <= divz_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;
  assign divz_o   = divz_q;

endmodule

// ===== hw/rtl/postfix_stack_evaluator.sv =====
// Postfix stack evaluator: one ASCII character per input transaction, one result per expression.
//
// Each input transaction carries one character of a postfix expression. Letters and digits push
// their code minus 48 onto a 16-entry signed 8-bit stack; + - * / % pop two operands and push the
// wrapped 8-bit result, and ^ pushes their bitwise XOR. All other characters are ignored. On the
// transaction marked end_of_expr the block returns one output transaction with the top of the
// stack and the first error seen in that expression (underflow, overflow, divide by zero, or empty
// stack at end), then clears the stack. The block takes one transaction at a time and holds
// in_stall_o high while it works: a pushed or ignored character only passes the decode and end
// states, + - * ^ also pop both operands and wait for the shared arithmetic unit, and / % take
// longest, because the quotient comes out of that unit one bit per cycle; a zero divisor is
// caught at once. The end-of-expression transaction also waits for the registered stack read
// and for the output register to drain. The output is registered, so a finished result may
// wait on out_stall_i while the next characters are already being taken.
`include "postfix_stack_evaluator_assert.svh"
module postfix_stack_evaluator import pse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pse_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pse_out_t out_data_o
);

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_POP_R  = 7'b0000100,
    S_POP_L  = 7'b0001000,
    S_EXEC   = 7'b0010000,
    S_END    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } seq_state_e;

  seq_state_e        state_q, state_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;
  logic signed [7:0] right_q, right_d;
  logic              popped_q, popped_d;
  status_e           err_q, err_d;
  logic              out_valid_q, out_valid_d;
  pse_out_t          out_data_q, out_data_d;

  pse_cls_t          cls;
  pse_stk_cmd_t      stk_cmd;
  pse_stk_sts_t      stk_sts;
  logic [7:0]        stk_rdata;
  logic              alu_start;
  logic signed [7:0] alu_a;
  logic              alu_done;
  logic [7:0]        alu_result;
  logic              alu_divz;
  logic              emit_go;

  assign cls   = decode_char(char_q);
  // The left operand comes straight from the stack read of the previous cycle.
  assign alu_a = popped_q ? stk_rdata : 8'sd0;
  // The result leaves once the output register is free or is being drained this cycle.
  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  pse_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stk_cmd),
    .sts_o   (stk_sts),
    .rdata_o (stk_rdata)
  );

  pse_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (alu_start),
    .op_i     (cls.op),
    .a_i      (alu_a),
    .b_i      (right_q),
    .done_o   (alu_done),
    .result_o (alu_result),
    .divz_o   (alu_divz)
  );

  always_comb begin
    state_d     = state_q;
    char_d      = char_q;
    last_d      = last_q;
    right_d     = right_q;
    popped_d    = popped_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    stk_cmd     = '0;
    alu_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          char_d  = in_data_i.char_code;
          last_d  = in_data_i.end_of_expr;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (cls.is_push) begin
          if (stk_sts.full) begin
            err_d = note_err(err_q, ST_OVER);
          end else begin
            stk_cmd.push  = 1'b1;
            stk_cmd.wdata = char_q - CH_ZERO;
          end
          state_d = S_END;
        end else if (cls.is_op) begin
          // Right operand pops first; an empty stack supplies zero.
          if (stk_sts.empty) begin
            err_d = note_err(err_q, ST_UNDER);
          end else begin
            stk_cmd.pop = 1'b1;
          end
          popped_d = !stk_sts.empty;
          state_d  = S_POP_R;
        end else begin
          state_d = S_END;
        end
      end
      S_POP_R: begin
        right_d = popped_q ? stk_rdata : 8'sd0;
        if (stk_sts.empty) begin
          err_d = note_err(err_q, ST_UNDER);
        end else begin
          stk_cmd.pop = 1'b1;
        end
        popped_d = !stk_sts.empty;
        state_d  = S_POP_L;
      end
      S_POP_L: begin
        alu_start = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        if (alu_done) begin
          if (alu_divz) begin
            err_d = note_err(err_q, ST_DIVZ);
          end
          if (stk_sts.full) begin
            err_d = note_err(alu_divz ? note_err(err_q, ST_DIVZ) : err_q, ST_OVER);
          end else begin
            stk_cmd.push  = 1'b1;
            stk_cmd.wdata = alu_result;
          end
          state_d = S_END;
        end
      end
      S_END: begin
        if (last_q) begin
          stk_cmd.peek = 1'b1;
          state_d      = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        // Wait for room in the output register, then report and start a fresh expression.
        if (emit_go) begin
          out_valid_d       = 1'b1;
          out_data_d.value  = stk_sts.empty ? 8'sd0 : stk_rdata;
          out_data_d.status = (stk_sts.empty && (err_q == ST_OK)) ? ST_EMPTY : err_q;
          stk_cmd.clear     = 1'b1;
          err_d             = ST_OK;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
      popped_q    <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      popped_q    <= popped_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    right_q    <= right_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PSE_ASSERT_IMPLIES(a_alu_done_in_exec, clk_i, rst_ni, alu_done, state_q == S_EXEC)
  `PSE_ASSERT_IMPLIES(a_status_range, clk_i, rst_ni, out_valid_q, out_data_q.status <= ST_EMPTY)
  `PSE_ASSERT_NEXT(a_emit_clears_err, clk_i, rst_ni, emit_go, (err_q == ST_OK) && out_valid_q)

endmodule

// ===== tb/sv/postfix_stack_evaluator_test.sv =====
// Self-checking testbench for the postfix stack evaluator with a predicting scoreboard.
`timescale 1ns / 100ps

module postfix_stack_evaluator_test import pse_pkg::*; ();

  // Idle cycles with no accepted transaction on either side before the run is declared hung.
  // The receiver's long hold, LONG_HOLD, is the longest legitimate quiet stretch, and this limit
  // is many times that.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned CHAR_BUDGET    = 1600;

  typedef logic [7:0] char_seq_t[$];

  // Tracks the evaluator's stack as characters are accepted and keeps the results that are
  // still due, oldest first.
  class postfix_tracker;
    logic [7:0]  stack_vals[STACK_DEPTH];
    int unsigned depth;
    status_e     first_err;
    pse_out_t    outcomes_due[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned status_tally[5];

    function new();
      depth     = 0;
      first_err = ST_OK;
      failures  = 0;
      checked   = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    static function bit is_operand(logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UZ) ||
             (c >= CH_LA && c <= CH_LZ);
    endfunction

    static function bit is_operator(logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
             c == CH_PCT || c == CH_CARET;
    endfunction

    // Only the first error of an expression is reported.
    function void flag(status_e code);
      if (first_err == ST_OK) first_err = code;
    endfunction

    function void push(logic [7:0] v);
      if (depth >= STACK_DEPTH) begin
        flag(ST_OVER);
      end else begin
        stack_vals[depth] = v;
        depth++;
      end
    endfunction

    function logic signed [7:0] pop();
      if (depth == 0) begin
        flag(ST_UNDER);
        return 8'sd0;
      end
      depth--;
      return $signed(stack_vals[depth]);
    endfunction

    function int unsigned outstanding();
      return outcomes_due.size();
    endfunction

    // Applies one accepted character and, on the last one, queues the result it produces.
    function void take_char(pse_in_t item);
      logic [7:0] c;
      int         lhs;
      int         rhs;
      int         res;
      pse_out_t   outcome;
      c = item.char_code;
      if (is_operand(c)) begin
        push(c - CH_ZERO);
      end else if (is_operator(c)) begin
        rhs = pop();
        lhs = pop();
        res = 0;
        case (c)
          CH_PLUS:  res = lhs + rhs;
          CH_MINUS: res = lhs - rhs;
          CH_STAR:  res = lhs * rhs;
          CH_SLASH: begin
            if (rhs == 0) flag(ST_DIVZ);
            else res = lhs / rhs;
          end
          CH_PCT: begin
            if (rhs == 0) flag(ST_DIVZ);
            else res = lhs % rhs;
          end
          default:  res = lhs ^ rhs;
        endcase
        push(res[7:0]);
      end
      if (item.end_of_expr) begin
        outcome.status = first_err;
        if (depth == 0) begin
          outcome.value = 8'sd0;
          if (first_err == ST_OK) outcome.status = ST_EMPTY;
        end else begin
          outcome.value = stack_vals[depth - 1];
        end
        outcomes_due.push_back(outcome);
        depth     = 0;
        first_err = ST_OK;
      end
    endfunction

    function void check_result(pse_out_t got);
      pse_out_t want;
      if (outcomes_due.size() == 0) begin
        $error("result (value %0d, status %0d) arrived with none outstanding",
               got.value, got.status);
        failures++;
        return;
      end
      want = outcomes_due.pop_front();
      checked++;
      status_tally[want.status]++;
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  pse_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pse_out_t out_data_o;

  postfix_tracker tracker = new();
  int unsigned    chars_sent   = 0;
  int unsigned    exprs_sent   = 0;
  int unsigned    idle_cycles  = 0;
  bit             quiet_sender = 1'b0;

  postfix_stack_evaluator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hang detector: any accepted transaction on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("postfix_stack_evaluator: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_operand();
    int unsigned r;
    // Zero is favored so that division and modulo by zero come up often.
    if ($urandom_range(0, 6) == 0) return CH_ZERO;
    r = $urandom_range(0, 61);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 36) return CH_UA + 8'(r - 10);
    return CH_LA + 8'(r - 36);
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] ops[6];
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET};
    return ops[$urandom_range(0, 5)];
  endfunction

  function automatic char_seq_t spell(string s);
    char_seq_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Builds one random expression. Most are well formed with random operands and operators,
  // some push deep and may overflow the stack, some are well formed but then damaged by a
  // dropped or extra character, and the rest are plain byte noise.
  function automatic char_seq_t random_expr();
    char_seq_t   q;
    int unsigned kind;
    int unsigned goal;
    int unsigned pushes;
    int unsigned depth;
    int unsigned n;
    logic [7:0]  c;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      n = $urandom_range(1, 6);
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
      return q;
    end
    if (kind >= 65 && kind < 75) begin
      n = $urandom_range(14, 20);
      repeat (n) q.push_back(pick_operand());
      repeat ($urandom_range(0, n)) q.push_back(pick_operator());
      return q;
    end
    goal   = $urandom_range(1, 8);
    pushes = 0;
    depth  = 0;
    while (pushes < goal || depth > 1) begin
      // Now and then a character the evaluator skips is slipped in.
      if ($urandom_range(0, 9) == 0) begin
        do c = 8'($urandom_range(0, 255));
        while (postfix_tracker::is_operand(c) || postfix_tracker::is_operator(c));
        q.push_back(c);
      end
      if (pushes < goal && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        q.push_back(pick_operand());
        depth++;
        pushes++;
      end else begin
        q.push_back(pick_operator());
        depth--;
      end
    end
    if (kind >= 75) begin
      if ($urandom_range(0, 1) == 1 && q.size() > 1) q.delete($urandom_range(0, q.size() - 1));
      else q.insert($urandom_range(0, q.size()), pick_operator());
    end
    return q;
  endfunction

  // Offers one character transaction after a random gap and returns at the edge that accepts
  // it. Valid is only lowered when a gap follows, so back-to-back transactions keep it high.
  task automatic send_char(input logic [7:0] c, input bit last);
    int unsigned gap;
    pse_in_t     item;
    gap              = quiet_sender ? 0 : $urandom_range(0, 19);
    item.char_code   = c;
    item.end_of_expr = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_char(item);
    chars_sent++;
  endtask

  task automatic send_expr(input char_seq_t chars);
    // About one expression in five goes out with no gaps at all.
    quiet_sender = ($urandom_range(0, 4) == 0);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    exprs_sent++;
  endtask

  // Stops offering characters until every outstanding result has come back. At least one edge
  // passes, so valid is never lowered and raised in the same step.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  // Result side: stall for a random number of cycles before each result, with stretches of no
  // stall and two long holds that back the evaluator up until it stalls its input.
  initial begin : result_sink
    int unsigned hold;
    int unsigned calm_left;
    int unsigned taken;
    calm_left = 0;
    taken     = 0;
    forever begin
      if (taken == 20 || taken == 180) begin
        hold = LONG_HOLD;
      end else if (calm_left > 0) begin
        hold = 0;
        calm_left--;
      end else begin
        hold = $urandom_range(0, 19);
        if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 30);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_result(out_data_o);
      taken++;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed expressions. 32 * 4 wraps to -128, which is then divided by -1 and wraps again.
    send_expr(spell("P4*01-/"));
    // Modulo of the largest operand range, then XOR.
    send_expr(spell("zA%3^"));
    send_expr(spell("9z+"));
    // Underflow comes first, so the later zero divide must not replace it.
    send_expr(spell("+0/"));
    send_expr(spell("50%"));
    // Only ignored characters, including both extremes and both sides of 128: empty at end.
    send_expr('{8'h00, 8'hFF, 8'h80, 8'h7F});
    drain_results();

    while (chars_sent < CHAR_BUDGET) begin
      send_expr(random_expr());
      if (exprs_sent % 150 == 0) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk_i);

    $display("Sent %0d characters in %0d expressions and compared %0d results.",
             chars_sent, exprs_sent, tracker.checked);
    $display("Outcomes: ok %0d, underflow %0d, overflow %0d, divide by zero %0d, empty %0d.",
             tracker.status_tally[ST_OK], tracker.status_tally[ST_UNDER],
             tracker.status_tally[ST_OVER], tracker.status_tally[ST_DIVZ],
             tracker.status_tally[ST_EMPTY]);
    if (tracker.failures == 0 && tracker.outstanding() == 0)
      $display("postfix_stack_evaluator: match");
    else
      $display("postfix_stack_evaluator: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pse_pkg.sv
hw/rtl/pse_stack.sv
hw/rtl/pse_alu.sv
hw/rtl/postfix_stack_evaluator.sv
tb/sv/postfix_stack_evaluator_test.sv
